FILE: rtl/core/tws_pkg.sv
// Shared types and constants for the textured wall column span block.
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

   localparam int NUM_W  = 23;  // dividend width: texture_height << 16
   localparam int DEN_W  = 16;  // divisor width: wall distance
   localparam int LINE_W = 15;  // line height, up to SCREEN_HEIGHT * 256
   localparam int HALF_W = 14;  // half line height
   localparam int ROW_W  = 6;
   localparam int COL_W  = 10;
   localparam int TCOL_W = 6;
   localparam int TNUM_W = 2;
   localparam int ADDR_W = 12;
   localparam int CFG_W  = 7;
   localparam int POS_W  = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TEXTURE_HEIGHT = 1'b0;
   localparam logic REG_TEXTURE_WIDTH  = 1'b1;

   typedef struct packed {
      logic load;        // capture the column's pass-through fields
      logic div_line;    // start line height division
      logic take_line;   // latch line height, rows and offset
      logic div_step;    // start texture step division
      logic take_step;   // latch texture step
      logic set_pos;     // load starting texture position
      logic emit;        // push one pixel into the output register
   } tws_cmd_type;

   typedef struct packed {
      logic column_ok;
      logic div_done;
      logic out_free;
      logic at_end;
   } tws_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/textured_wall_column_span.sv
// Top level of the textured wall column span block with its register port.
//
// One transfer on req_ carries a screen column: Q8.8 wall distance, texture
// column, texture number and screen x. The block answers with one rsp_
// transfer per drawn screen row, top to bottom, each with the texel address
// (texture row * texture_width + texture column); last_row marks the final
// row. A column at or beyond SCREEN_WIDTH is taken and gives no transfers.
// Line height and texture step come from one shared radix-2 divider. After
// the req_ transfer the block runs the line height division, then the
// texture step division, and sets the starting texture position; the rows
// then follow one per cycle while rsp_ready stays high. req_ready is high
// only between columns; the last pixel may still wait in the output register
// while the next column is taken. A stalled receiver holds the row walk.
// Reset is synchronous: it clears the controller and the output valid, and
// sets texture_height and texture_width to 64. Registers (csr_, byte
// addresses): 0 texture_height, 4 texture_width; write them only while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module textured_wall_column_span #(
   parameter int SCREEN_HEIGHT = 64,
   parameter int SCREEN_WIDTH  = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [15:0]                       req_wall_distance,
   input  wire logic [tws_pkg::TCOL_W-1:0]        req_texture_column,
   input  wire logic [tws_pkg::TNUM_W-1:0]        req_texture_number,
   input  wire logic [tws_pkg::COL_W-1:0]         req_screen_column,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [tws_pkg::COL_W-1:0]         rsp_pixel_column,
   output logic      [tws_pkg::ROW_W-1:0]         rsp_pixel_row,
   output logic      [tws_pkg::TNUM_W-1:0]        rsp_texel_texture,
   output logic      [tws_pkg::ADDR_W-1:0]        rsp_texel_address,
   output logic                                   rsp_last_row,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tws_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [tws_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [tws_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import tws_pkg::*;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

   logic [CFG_W-1:0] texture_height_ff, texture_height_in;
   logic [CFG_W-1:0] texture_width_ff, texture_width_in;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      texture_height_in = texture_height_ff;
      texture_width_in  = texture_width_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TEXTURE_HEIGHT: texture_height_in = csr_pwdata[CFG_W-1:0];
            REG_TEXTURE_WIDTH:  texture_width_in  = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texture_height_ff <= CFG_RESET;
         texture_width_ff  <= CFG_RESET;
      end else begin
         texture_height_ff <= texture_height_in;
         texture_width_ff  <= texture_width_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TEXTURE_HEIGHT) ?
                       CSR_DATA_W'(texture_height_ff) : CSR_DATA_W'(texture_width_ff);

   tws_cmd_type    cmd;
   tws_status_type status;

   tws_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tws_datapath #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .SCREEN_WIDTH  (SCREEN_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .texture_height     (texture_height_ff),
      .texture_width      (texture_width_ff),
      .req_wall_distance  (req_wall_distance),
      .req_texture_column (req_texture_column),
      .req_texture_number (req_texture_number),
      .req_screen_column  (req_screen_column),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_column   (rsp_pixel_column),
      .rsp_pixel_row      (rsp_pixel_row),
      .rsp_texel_texture  (rsp_texel_texture),
      .rsp_texel_address  (rsp_texel_address),
      .rsp_last_row       (rsp_last_row)
   );

   a_row_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_pixel_row} <= (ROW_W+1)'(SCREEN_HEIGHT - 1)))
      else $error("pixel row beyond screen");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.column_ok) |=> !req_ready)
      else $error("new column taken while a span is in progress");

   a_div_only_busy: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_ready)
      else $error("divider finished while idle");

endmodule

`default_nettype wire

FILE: rtl/core/tws_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tws_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [tws_pkg::NUM_W-1:0] numerator,
   input  wire logic [tws_pkg::DEN_W-1:0] divisor,
   output logic                           done,
   output logic      [tws_pkg::NUM_W-1:0] quotient
);
   import tws_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = numerator;
         den_in   = divisor;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tws_datapath.sv
// Datapath: divisions, span clipping, texture stepping and output register.
`timescale 1ns / 1ps
`default_nettype none

module tws_datapath #(
   parameter int SCREEN_HEIGHT = 64,
   parameter int SCREEN_WIDTH  = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tws_pkg::tws_cmd_type        cmd,
   output tws_pkg::tws_status_type          status,
   input  wire logic [tws_pkg::CFG_W-1:0]   texture_height,
   input  wire logic [tws_pkg::CFG_W-1:0]   texture_width,
   input  wire logic [15:0]                 req_wall_distance,
   input  wire logic [tws_pkg::TCOL_W-1:0]  req_texture_column,
   input  wire logic [tws_pkg::TNUM_W-1:0]  req_texture_number,
   input  wire logic [tws_pkg::COL_W-1:0]   req_screen_column,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [tws_pkg::COL_W-1:0]   rsp_pixel_column,
   output logic      [tws_pkg::ROW_W-1:0]   rsp_pixel_row,
   output logic      [tws_pkg::TNUM_W-1:0]  rsp_texel_texture,
   output logic      [tws_pkg::ADDR_W-1:0]  rsp_texel_address,
   output logic                             rsp_last_row
);
   import tws_pkg::*;

   localparam int HALF     = SCREEN_HEIGHT / 2;
   localparam int LAST_ROW = SCREEN_HEIGHT - 1;
   localparam logic [NUM_W-1:0] LINE_NUM = NUM_W'(SCREEN_HEIGHT * 256);
   localparam int PROD_W = HALF_W + NUM_W;

   logic [COL_W-1:0]  held_column_ff, held_column_in;
   logic [TCOL_W-1:0] held_tcol_ff, held_tcol_in;
   logic [TNUM_W-1:0] held_tnum_ff, held_tnum_in;
   logic [LINE_W-1:0] line_height_ff, line_height_in;
   logic [HALF_W-1:0] offset_ff, offset_in;
   logic [ROW_W-1:0]  current_row_ff, current_row_in;
   logic [ROW_W-1:0]  end_row_ff, end_row_in;
   logic [NUM_W-1:0]  step_ff, step_in;
   logic [POS_W-1:0]  position_ff, position_in;

   logic              out_valid_ff, out_valid_in;
   logic [COL_W-1:0]  out_column_ff, out_column_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [TNUM_W-1:0] out_tnum_ff, out_tnum_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              out_last_ff, out_last_in;

   // Shared divider
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den;

   assign div_start = cmd.div_line | cmd.div_step;
   assign div_num   = cmd.div_line ? LINE_NUM : {texture_height, 16'h0000};
   assign div_den   = cmd.div_line ?
                      ((req_wall_distance == '0) ? DEN_W'(1) : req_wall_distance) :
                      {1'b0, line_height_ff};

   tws_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo)
   );

   // Span geometry from the line height quotient
   logic [LINE_W-1:0] lh;
   logic [HALF_W-1:0] half_line, half_gap;
   logic              hl_ge;
   logic [LINE_W-1:0] end_sum;
   logic [ROW_W-1:0]  start_row, stop_row;

   assign lh        = (div_quo[LINE_W-1:0] == '0) ? LINE_W'(1) : div_quo[LINE_W-1:0];
   assign half_line = lh[LINE_W-1:1];
   assign hl_ge     = half_line >= HALF_W'(HALF);
   assign half_gap  = HALF_W'(HALF) - half_line;
   assign start_row = hl_ge ? '0 : half_gap[ROW_W-1:0];
   assign end_sum   = LINE_W'(HALF) + {1'b0, half_line};
   assign stop_row  = (end_sum > LINE_W'(LAST_ROW)) ? ROW_W'(LAST_ROW) : end_sum[ROW_W-1:0];

   // Starting position and texel address
   logic [PROD_W-1:0]  product;
   logic [CFG_W-1:0]   wrap_mask, tex_row;
   logic [2*CFG_W-1:0] row_base;
   logic [2*CFG_W-1:0] addr_full;
   logic               out_free, at_end;

   assign product   = PROD_W'(offset_ff) * PROD_W'(step_ff);
   assign wrap_mask = texture_height - CFG_W'(1);
   assign tex_row   = position_ff[16 +: CFG_W] & wrap_mask;
   assign row_base  = (2*CFG_W)'(tex_row) * (2*CFG_W)'(texture_width);
   assign addr_full = row_base + (2*CFG_W)'(held_tcol_ff);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign at_end    = current_row_ff == end_row_ff;

   always_comb begin
      held_column_in = held_column_ff;
      held_tcol_in   = held_tcol_ff;
      held_tnum_in   = held_tnum_ff;
      line_height_in = line_height_ff;
      offset_in      = offset_ff;
      current_row_in = current_row_ff;
      end_row_in     = end_row_ff;
      step_in        = step_ff;
      position_in    = position_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_column_in  = out_column_ff;
      out_row_in     = out_row_ff;
      out_tnum_in    = out_tnum_ff;
      out_addr_in    = out_addr_ff;
      out_last_in    = out_last_ff;
      if (cmd.load) begin
         held_column_in = req_screen_column;
         held_tcol_in   = req_texture_column;
         held_tnum_in   = req_texture_number;
      end
      if (cmd.take_line) begin
         line_height_in = lh;
         offset_in      = hl_ge ? half_line - HALF_W'(HALF) : '0;
         current_row_in = start_row;
         end_row_in     = stop_row;
      end
      if (cmd.take_step) begin
         step_in = div_quo;
      end
      if (cmd.set_pos) begin
         position_in = product[POS_W-1:0];
      end
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_column_in = held_column_ff;
         out_row_in    = current_row_ff;
         out_tnum_in   = held_tnum_ff;
         out_addr_in   = addr_full[ADDR_W-1:0];
         out_last_in   = at_end;
         position_in   = position_ff + POS_W'(step_ff);
         if (!at_end) begin
            current_row_in = current_row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      held_column_ff <= held_column_in;
      held_tcol_ff   <= held_tcol_in;
      held_tnum_ff   <= held_tnum_in;
      line_height_ff <= line_height_in;
      offset_ff      <= offset_in;
      current_row_ff <= current_row_in;
      end_row_ff     <= end_row_in;
      step_ff        <= step_in;
      position_ff    <= position_in;
      out_column_ff  <= out_column_in;
      out_row_ff     <= out_row_in;
      out_tnum_ff    <= out_tnum_in;
      out_addr_ff    <= out_addr_in;
      out_last_ff    <= out_last_in;
   end

   assign status.column_ok = {1'b0, req_screen_column} < (COL_W+1)'(SCREEN_WIDTH);
   assign status.div_done  = div_done;
   assign status.out_free  = out_free;
   assign status.at_end    = at_end;

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_column  = out_column_ff;
   assign rsp_pixel_row     = out_row_ff;
   assign rsp_texel_texture = out_tnum_ff;
   assign rsp_texel_address = out_addr_ff;
   assign rsp_last_row      = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tws_control.sv
// Controller: sequences the two divisions, the position setup and the row walk.
`timescale 1ns / 1ps
`default_nettype none

module tws_control (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tws_pkg::tws_status_type  status,
   output tws_pkg::tws_cmd_type          cmd
);
   import tws_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_LINE     = 3'd1;
   localparam logic [2:0] ST_STEP_GO  = 3'd2;
   localparam logic [2:0] ST_STEP     = 3'd3;
   localparam logic [2:0] ST_POSITION = 3'd4;
   localparam logic [2:0] ST_EMIT     = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load     = req_valid;
            cmd.div_line = req_valid && status.column_ok;
            if (req_valid && status.column_ok) begin
               state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            if (status.div_done) begin
               cmd.take_line = 1'b1;
               state_in      = ST_STEP_GO;
            end
         end
         ST_STEP_GO: begin
            cmd.div_step = 1'b1;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            if (status.div_done) begin
               cmd.take_step = 1'b1;
               state_in      = ST_POSITION;
            end
         end
         ST_POSITION: begin
            cmd.set_pos = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.at_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

`default_nettype wire
